// File: src/tmcw_pkg.sv
// tmcw_pkg: shared constants and types for the text mode console writer
// no dependencies; imported by text_mode_console_writer and the testbench
`timescale 1ns / 1ps
`default_nettype none

package tmcw_pkg;

    // default screen geometry
    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;

    // fixed field widths of the stream words
    localparam int MODE_W   = 3;
    localparam int CHAR_W   = 8;
    localparam int COLUMN_W = 7;
    localparam int ROW_W    = 5;
    localparam int ATTR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int PW_W     = 7;
    localparam int DATA_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUT_CURSOR = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUT_CELL   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BACKSPACE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ_CELL  = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_ATTR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROMPT_WIDTH = 2'd2;

    // register reset values
    localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;
    localparam logic [PW_W-1:0]   PROMPT_WIDTH_RST = 7'd6;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_ERROR   = 8'h45;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;

    // one screen cell as held in the store
    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] ch;
    } cell_t;

endpackage

`default_nettype wire

// File: src/text_mode_console_writer.sv
// text_mode_console_writer: text console over a cell store with one write and one read port
// depends on tmcw_pkg (constants, cell_t)
`timescale 1ns / 1ps
`default_nettype none

// The console keeps COLS x ROWS cells (character in the low byte, attribute
// in the high byte) in one synchronous memory and a cursor as a column/row
// pair. Each input word carries one command and yields exactly one result
// word with the status, the cursor after the command and, for a read, the
// cell contents. After reset the block first zeroes the store, one cell a
// cycle; s_tready stays low meanwhile while configuration writes are
// still taken. The one write port of the memory sets the long commands:
// a clear sweeps every cell, and a put that runs past the last cell
// scrolls by moving every row up one cell a cycle and then zeroing the
// bottom row. One command is in work at a time; the result sits in an
// output register, so the next word is accepted while an earlier result
// is still waiting to be taken.
module text_mode_console_writer
    import tmcw_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,

    // command stream
    input  wire                   s_tvalid,
    output logic                  s_tready,
    // tdata: char_code[7:0], column[14:8], row[19:15], attribute[27:20], zero pad
    input  wire  [DATA_W-1:0]     s_tdata,
    // tuser: mode[2:0]
    input  wire  [MODE_W-1:0]     s_tuser,

    // result stream
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // tdata: cursor_column[6:0], cursor_row[11:7], cell_char[19:12],
    //        cell_attr[27:20], zero pad
    output logic [DATA_W-1:0]     m_tdata,
    // tuser: status[1:0]
    output logic [STATUS_W-1:0]   m_tuser,

    // configuration writes
    input  wire                   cfg_we,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_data
);

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CCOL_W = $clog2(COLS);
    localparam int CROW_W = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - COLS);
    localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLS);
    localparam logic [CCOL_W-1:0] LAST_COL   = CCOL_W'(COLS - 1);
    localparam logic [CROW_W-1:0] LAST_ROW   = CROW_W'(ROWS - 1);

    // controller states
    localparam logic [3:0] S_INIT        = 4'd0;
    localparam logic [3:0] S_IDLE        = 4'd1;
    localparam logic [3:0] S_ADDR        = 4'd2;
    localparam logic [3:0] S_EXEC        = 4'd3;
    localparam logic [3:0] S_READ        = 4'd4;
    localparam logic [3:0] S_SCROLL      = 4'd5;
    localparam logic [3:0] S_SCROLL_TAIL = 4'd6;
    localparam logic [3:0] S_FILL        = 4'd7;
    localparam logic [3:0] S_RESP        = 4'd8;

    // cell store
    cell_t mem [CELLS];
    cell_t rd_data_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    cell_t             mem_wd;
    logic [ADDR_W-1:0] mem_ra;

    // control state
    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              mv_vld_reg, mv_vld_next;
    logic [CCOL_W-1:0] cur_col_reg, cur_col_next;
    logic [CROW_W-1:0] cur_row_reg, cur_row_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // configuration
    logic [ATTR_W-1:0] default_attr_reg;
    logic [ATTR_W-1:0] error_attr_reg;
    logic [PW_W-1:0]   prompt_width_reg;

    // payload
    logic [ADDR_W-1:0]   mv_addr_reg, mv_addr_next;
    cell_t               fill_reg, fill_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [COLUMN_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ATTR_W-1:0]   attr_reg, attr_next;
    logic [CCOL_W-1:0]   pcol_reg, pcol_next;
    logic [CROW_W-1:0]   prow_reg, prow_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CHAR_W-1:0]   rchar_reg, rchar_next;
    logic [ATTR_W-1:0]   rattr_reg, rattr_next;
    logic [DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg, m_tuser_next;

    // decode helpers
    logic              in_range;
    logic              cur_zero;
    logic              do_put;
    logic              wraps;
    logic [CROW_W-1:0] nrow;
    logic [ATTR_W-1:0] put_attr;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign in_range = ({1'b0, col_reg} < (COLUMN_W + 1)'(COLS))
                   && ({1'b0, row_reg} < (ROW_W + 1)'(ROWS));
    assign cur_zero = (cur_col_reg == '0) && (cur_row_reg == '0);
    assign do_put   = (mode_reg == MODE_PUT_CURSOR)
                   || ((mode_reg == MODE_PUT_CELL) && in_range);
    // newline or a character in the last column moves to the next row
    assign wraps    = (char_reg == CH_NEWLINE) || (pcol_reg == LAST_COL);
    assign nrow     = prow_reg + CROW_W'(1);
    assign put_attr = (attr_reg == '0) ? default_attr_reg : attr_reg;

    // memory port: one write and one registered read per cycle
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = '0;
        mem_ra = addr_reg;
        case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                mem_wa = ptr_reg;
            end
            S_EXEC:
            begin
                if (do_put && (char_reg != CH_NEWLINE))
                begin
                    mem_we = 1'b1;
                    mem_wd = '{attr: put_attr, ch: char_reg};
                end
                else if ((mode_reg == MODE_PUT_CELL) && !in_range)
                begin
                    // error mark goes to the last cell
                    mem_we = 1'b1;
                    mem_wd = '{attr: error_attr_reg, ch: CH_ERROR};
                end
                else if ((mode_reg == MODE_BACKSPACE) && !cur_zero
                         && (PW_W'(pcol_reg) > prompt_width_reg))
                begin
                    mem_we = 1'b1;
                    mem_wd = '{attr: default_attr_reg, ch: CH_BLANK};
                end
            end
            S_SCROLL, S_SCROLL_TAIL:
            begin
                // move the cell held in the read register up one row
                mem_we = mv_vld_reg;
                mem_wa = mv_addr_reg;
                mem_wd = rd_data_reg;
                mem_ra = ptr_reg;
            end
            S_FILL:
            begin
                mem_we = 1'b1;
                mem_wa = ptr_reg;
                mem_wd = fill_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // command sequencer
    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        mv_vld_next   = 1'b0;
        mv_addr_next  = mv_addr_reg;
        fill_next     = fill_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        mode_next     = mode_reg;
        char_next     = char_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        attr_next     = attr_reg;
        pcol_next     = pcol_reg;
        prow_next     = prow_reg;
        addr_next     = addr_reg;
        status_next   = status_reg;
        rchar_next    = rchar_reg;
        rattr_next    = rattr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tuser;
                    char_next  = s_tdata[7:0];
                    col_next   = s_tdata[14:8];
                    row_next   = s_tdata[19:15];
                    attr_next  = s_tdata[27:20];
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                // pick the cell this command works on
                pcol_next = cur_col_reg;
                prow_next = cur_row_reg;
                if ((mode_reg == MODE_PUT_CELL) || (mode_reg == MODE_READ_CELL))
                begin
                    if (in_range)
                    begin
                        pcol_next = col_reg[CCOL_W-1:0];
                        prow_next = row_reg[CROW_W-1:0];
                    end
                    else
                    begin
                        pcol_next = LAST_COL;
                        prow_next = LAST_ROW;
                    end
                end
                else if (mode_reg == MODE_BACKSPACE)
                begin
                    if (cur_col_reg == '0)
                    begin
                        pcol_next = LAST_COL;
                        prow_next = cur_row_reg - CROW_W'(1);
                    end
                    else
                    begin
                        pcol_next = cur_col_reg - CCOL_W'(1);
                    end
                end
                addr_next  = ADDR_W'(prow_next) * ROW_STEP + ADDR_W'(pcol_next);
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                status_next = ST_DONE;
                rchar_next  = '0;
                rattr_next  = '0;
                state_next  = S_RESP;
                case (mode_reg)
                    MODE_PUT_CURSOR, MODE_PUT_CELL:
                    begin
                        if (!in_range && (mode_reg == MODE_PUT_CELL))
                        begin
                            status_next = ST_RANGE;
                        end
                        else if (wraps && (prow_reg == LAST_ROW))
                        begin
                            // ran past the last cell: scroll, cursor on bottom row
                            cur_col_next = '0;
                            cur_row_next = LAST_ROW;
                            ptr_next     = ROW_STEP;
                            state_next   = S_SCROLL;
                        end
                        else if (wraps)
                        begin
                            cur_col_next = '0;
                            cur_row_next = nrow;
                        end
                        else
                        begin
                            cur_col_next = pcol_reg + CCOL_W'(1);
                            cur_row_next = prow_reg;
                        end
                    end
                    MODE_BACKSPACE:
                    begin
                        if (!cur_zero && (PW_W'(pcol_reg) > prompt_width_reg))
                        begin
                            cur_col_next = pcol_reg;
                            cur_row_next = prow_reg;
                        end
                        else
                        begin
                            status_next = ST_REFUSED;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        cur_col_next = '0;
                        cur_row_next = '0;
                        fill_next    = '{attr: default_attr_reg, ch: CH_BLANK};
                        ptr_next     = '0;
                        state_next   = S_FILL;
                    end
                    MODE_READ_CELL:
                    begin
                        if (in_range)
                        begin
                            state_next = S_READ;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                        end
                    end
                    default:
                    begin
                        status_next = ST_DONE;
                    end
                endcase
            end
            S_READ:
            begin
                rchar_next = rd_data_reg.ch;
                rattr_next = rd_data_reg.attr;
                state_next = S_RESP;
            end
            S_SCROLL:
            begin
                mv_vld_next  = 1'b1;
                mv_addr_next = ptr_reg - ROW_STEP;
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = S_SCROLL_TAIL;
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            S_SCROLL_TAIL:
            begin
                // last move lands now; then zero the bottom row
                fill_next  = '0;
                ptr_next   = BOTTOM_ROW;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, rattr_reg, rchar_reg,
                                     ROW_W'(cur_row_reg), COLUMN_W'(cur_col_reg)};
                    m_tuser_next  = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            ptr_reg      <= '0;
            mv_vld_reg   <= 1'b0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            mv_vld_reg   <= mv_vld_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= DEFAULT_ATTR_RST;
            error_attr_reg   <= ERROR_ATTR_RST;
            prompt_width_reg <= PROMPT_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEFAULT_ATTR: default_attr_reg <= cfg_data;
                REG_ERROR_ATTR:   error_attr_reg   <= cfg_data;
                REG_PROMPT_WIDTH: prompt_width_reg <= cfg_data[PW_W-1:0];
                default:          default_attr_reg <= default_attr_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mv_addr_reg <= mv_addr_next;
        fill_reg    <= fill_next;
        mode_reg    <= mode_next;
        char_reg    <= char_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        attr_reg    <= attr_next;
        pcol_reg    <= pcol_next;
        prow_reg    <= prow_next;
        addr_reg    <= addr_next;
        status_reg  <= status_next;
        rchar_reg   <= rchar_next;
        rattr_reg   <= rattr_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // cursor never leaves the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cur_col_reg) < COLS) && (int'(cur_row_reg) < ROWS))
        else $error("cursor off screen");

    // an accepted command always starts with address selection
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_ADDR))
        else $error("accepted command not sequenced");

    // a new result only comes out of the response state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == S_RESP))
        else $error("result raised outside response state");

    // scroll moves never write into the bottom row
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCROLL || state_reg == S_SCROLL_TAIL) && mv_vld_reg)
            |-> (mv_addr_reg < BOTTOM_ROW))
        else $error("scroll move hits bottom row");

    // no command is taken while the store is being swept
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL || state_reg == S_SCROLL) |=> !(s_tvalid && s_tready))
        else $error("command accepted during sweep");

endmodule

`default_nettype wire

// File: test/testbench.sv
// testbench: self-checking bench for the text mode console writer
// holds a screen mirror class that predicts every result word, plus the stream drivers
// depends on tmcw_pkg and text_mode_console_writer
`timescale 1ns / 1ps

import tmcw_pkg::*;

// one result word split into its fields
typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COLUMN_W-1:0] cur_col;
    logic [ROW_W-1:0]    cur_row;
    logic [CHAR_W-1:0]   ch;
    logic [ATTR_W-1:0]   attr;
} console_reply_t;

class console_mirror;
    cell_t               screen[COLS_DEF * ROWS_DEF];
    int                  cursor;
    logic [ATTR_W-1:0]   default_attr;
    logic [ATTR_W-1:0]   error_attr;
    logic [PW_W-1:0]     prompt_width;
    console_reply_t      due_replies[$];
    int                  failures;

    function new();
        reset_state();
        failures = 0;
    endfunction

    function void reset_state();
        foreach (screen[i])
            screen[i] = '0;
        cursor = 0;
        default_attr = DEFAULT_ATTR_RST;
        error_attr = ERROR_ATTR_RST;
        prompt_width = PROMPT_WIDTH_RST;
        due_replies.delete();
    endfunction

    function void set_register(input logic [CFG_IDX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] value);
        case (index)
            REG_DEFAULT_ATTR: default_attr = value;
            REG_ERROR_ATTR:   error_attr = value;
            REG_PROMPT_WIDTH: prompt_width = value[PW_W-1:0];
            default: ;
        endcase
    endfunction

    function int next_cursor(input int pos, input logic [CHAR_W-1:0] ch);
        if (ch == CH_NEWLINE)
            return (pos / COLS_DEF + 1) * COLS_DEF;
        return pos + 1;
    endfunction

    // true when the command makes the block walk the whole store
    function bit sweeps_store(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                              input logic [COLUMN_W-1:0] col, input logic [ROW_W-1:0] row);
        if (mode == MODE_CLEAR)
            return 1'b1;
        if (mode == MODE_PUT_CURSOR)
            return next_cursor(cursor, ch) >= COLS_DEF * ROWS_DEF;
        if (mode == MODE_PUT_CELL && col < COLS_DEF && row < ROWS_DEF)
            return next_cursor(int'(row) * COLS_DEF + int'(col), ch) >= COLS_DEF * ROWS_DEF;
        return 1'b0;
    endfunction

    function void place_char(input int pos, input logic [CHAR_W-1:0] ch,
                             input logic [ATTR_W-1:0] attr);
        int next;
        next = next_cursor(pos, ch);
        if (ch != CH_NEWLINE)
        begin
            screen[pos].ch = ch;
            screen[pos].attr = (attr == '0) ? default_attr : attr;
        end
        if (next >= COLS_DEF * ROWS_DEF)
        begin
            // scroll: every row up one, bottom row zeroed
            for (int i = 0; i < COLS_DEF * (ROWS_DEF - 1); i++)
                screen[i] = screen[i + COLS_DEF];
            for (int i = COLS_DEF * (ROWS_DEF - 1); i < COLS_DEF * ROWS_DEF; i++)
                screen[i] = '0;
            next -= COLS_DEF;
        end
        cursor = next;
    endfunction

    function void accept_command(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                                 input logic [COLUMN_W-1:0] col, input logic [ROW_W-1:0] row,
                                 input logic [ATTR_W-1:0] attr);
        console_reply_t reply;
        bit             in_range;
        int             pos;
        reply = '0;
        in_range = (col < COLS_DEF) && (row < ROWS_DEF);
        pos = int'(row) * COLS_DEF + int'(col);
        case (mode)
            MODE_PUT_CURSOR: place_char(cursor, ch, attr);
            MODE_PUT_CELL:
                if (in_range)
                    place_char(pos, ch, attr);
                else
                begin
                    screen[COLS_DEF * ROWS_DEF - 1].ch = CH_ERROR;
                    screen[COLS_DEF * ROWS_DEF - 1].attr = error_attr;
                    reply.status = ST_RANGE;
                end
            MODE_BACKSPACE:
                if (cursor == 0 || (cursor - 1) % COLS_DEF <= int'(prompt_width))
                    reply.status = ST_REFUSED;
                else
                begin
                    cursor--;
                    screen[cursor].ch = CH_BLANK;
                    screen[cursor].attr = default_attr;
                end
            MODE_CLEAR:
            begin
                foreach (screen[i])
                begin
                    screen[i].ch = CH_BLANK;
                    screen[i].attr = default_attr;
                end
                cursor = 0;
            end
            MODE_READ_CELL:
                if (in_range)
                begin
                    reply.ch = screen[pos].ch;
                    reply.attr = screen[pos].attr;
                end
                else
                    reply.status = ST_RANGE;
            default: ;
        endcase
        reply.cur_col = COLUMN_W'(cursor % COLS_DEF);
        reply.cur_row = ROW_W'(cursor / COLS_DEF);
        due_replies.push_back(reply);
    endfunction

    function void note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endfunction

    function void check_reply(input logic [STATUS_W-1:0] status,
                              input logic [DATA_W-1:0] data);
        console_reply_t got;
        console_reply_t want;
        got.status = status;
        got.cur_col = data[COLUMN_W-1:0];
        got.cur_row = data[COLUMN_W +: ROW_W];
        got.ch = data[COLUMN_W + ROW_W +: CHAR_W];
        got.attr = data[COLUMN_W + ROW_W + CHAR_W +: ATTR_W];
        if (due_replies.size() == 0)
        begin
            note_failure($sformatf("unexpected word: status %0d cursor (%0d,%0d) cell %02h/%02h",
                got.status, got.cur_col, got.cur_row, got.ch, got.attr));
            return;
        end
        want = due_replies.pop_front();
        if (got.status !== want.status || got.cur_col !== want.cur_col ||
            got.cur_row !== want.cur_row || got.ch !== want.ch || got.attr !== want.attr)
            note_failure($sformatf({"mismatch: expected status %0d cursor (%0d,%0d) ",
                "cell %02h/%02h, got status %0d cursor (%0d,%0d) cell %02h/%02h"},
                want.status, want.cur_col, want.cur_row, want.ch, want.attr,
                got.status, got.cur_col, got.cur_row, got.ch, got.attr));
    endfunction

    function int outstanding();
        return due_replies.size();
    endfunction

    function void check_drained();
        if (due_replies.size() != 0)
            note_failure($sformatf("%0d result words never arrived", due_replies.size()));
    endfunction
endclass

module testbench;

    // worst correct run: ~625 words, each a full store sweep, plus receiver
    // stalls; the limit is set well above that
    localparam int MAX_CYCLES      = 6_000_000;
    localparam int PHASE_WORDS     = 200;
    // store sweeps (clear, scroll) allowed per random phase, keeps the run short
    localparam int SWEEPS_PER_PHASE = 40;
    // cycles after the last result, before the final drain check
    localparam int SETTLE_CYCLES   = 16;
    localparam logic [MODE_W-1:0] FIRST_UNUSED_MODE = MODE_READ_CELL + 1'b1;
    localparam logic [MODE_W-1:0] LAST_MODE         = '1;
    localparam int COLUMN_MAX = (1 << COLUMN_W) - 1;
    localparam int ROW_MAX    = (1 << ROW_W) - 1;

    // field-sized forms of the screen geometry
    localparam logic [COLUMN_W-1:0] COL_LIMIT = COLUMN_W'(COLS_DEF);
    localparam logic [ROW_W-1:0]    ROW_LIMIT = ROW_W'(ROWS_DEF);
    localparam logic [COLUMN_W-1:0] COL_TOP   = COLUMN_W'(COLUMN_MAX);
    localparam logic [ROW_W-1:0]    ROW_TOP   = ROW_W'(ROW_MAX);

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // tdata: char_code[7:0], column[14:8], row[19:15], attribute[27:20], zero pad
    logic [DATA_W-1:0]     s_tdata;
    // tuser: mode[2:0]
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // tdata: cursor_column[6:0], cursor_row[11:7], cell_char[19:12], cell_attr[27:20]
    logic [DATA_W-1:0]     m_tdata;
    // tuser: status[1:0]
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    console_mirror mirror;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            sweeps_left;
    int            cycle_count = 0;

    text_mode_console_writer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // receiver: stall decided per cycle on the falling edge
    always @(negedge clk)
        m_tready = (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

    // every accepted result word goes straight to the mirror
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            mirror.check_reply(m_tuser, m_tdata);

    // hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one command word; called and returns on a falling edge
    task automatic send_command(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                                input logic [COLUMN_W-1:0] col, input logic [ROW_W-1:0] row,
                                input logic [ATTR_W-1:0] attr);
        // sender gap now and then
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = mode;
        s_tdata = {4'd0, attr, row, col, ch};
        do
            @(posedge clk);
        while (!s_tready);
        mirror.accept_command(mode, ch, col, row, attr);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        @(posedge clk);
        mirror.set_register(index, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_console(input logic [ATTR_W-1:0] dflt, input logic [ATTR_W-1:0] err,
                               input logic [PW_W-1:0] prompt);
        write_register(REG_DEFAULT_ATTR, dflt);
        write_register(REG_ERROR_ATTR, err);
        write_register(REG_PROMPT_WIDTH, CFG_DATA_W'(prompt));
    endtask

    // wait until every expected word has come back
    task automatic drain();
        s_tvalid = 1'b0;
        while (mirror.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // position of the cell just before the cursor, where the last char landed
    task automatic aim_at_last_write(output logic [COLUMN_W-1:0] col,
                                     output logic [ROW_W-1:0] row);
        int pos;
        pos = (mirror.cursor == 0) ? 0 : mirror.cursor - 1;
        col = COLUMN_W'(pos % COLS_DEF);
        row = ROW_W'(pos / COLS_DEF);
    endtask

    task automatic run_directed();
        // fresh store reads zero, out of range read, backspace at the first cell
        send_command(MODE_READ_CELL, 8'h00, 7'd0, 5'd0, 8'h00);
        send_command(MODE_READ_CELL, 8'hff, COL_TOP, ROW_TOP, 8'hff);
        send_command(MODE_BACKSPACE, 8'h00, 7'd0, 5'd0, 8'h00);
        // puts at the cursor: default attribute, all-ones, newline
        send_command(MODE_PUT_CURSOR, "A", 7'd0, 5'd0, 8'h00);
        send_command(MODE_PUT_CURSOR, 8'hff, COL_TOP, ROW_TOP, 8'hff);
        send_command(MODE_PUT_CURSOR, CH_NEWLINE, 7'd0, 5'd0, 8'h55);
        send_command(MODE_READ_CELL, 8'h00, 7'd1, 5'd0, 8'h00);
        // backspace allowed past the prompt, refused at its edge
        send_command(MODE_PUT_CELL, "x", 7'd10, 5'd0, 8'h12);
        send_command(MODE_BACKSPACE, 8'h00, 7'd0, 5'd0, 8'h00);
        send_command(MODE_PUT_CELL, 8'h00, 7'd7, 5'd1, 8'h00);
        send_command(MODE_BACKSPACE, 8'h00, 7'd0, 5'd0, 8'h00);
        send_command(MODE_BACKSPACE, 8'h00, 7'd0, 5'd0, 8'h00);
        // out of range puts mark the last cell
        send_command(MODE_PUT_CELL, "y", COL_LIMIT, 5'd0, 8'h33);
        send_command(MODE_PUT_CELL, "y", 7'd0, ROW_LIMIT, 8'h33);
        send_command(MODE_READ_CELL, 8'h00, COL_LIMIT - 7'd1, ROW_LIMIT - 5'd1, 8'h00);
        // newline at a cell, then scroll by passing the last cell
        send_command(MODE_PUT_CELL, CH_NEWLINE, 7'd5, 5'd3, 8'h00);
        send_command(MODE_PUT_CELL, "q", COL_LIMIT - 7'd2, ROW_LIMIT - 5'd1, 8'h21);
        send_command(MODE_PUT_CURSOR, "r", 7'd0, 5'd0, 8'h00);
        send_command(MODE_READ_CELL, 8'h00, COL_LIMIT - 7'd1, ROW_LIMIT - 5'd2, 8'h00);
        // newline at a bottom-row cell scrolls too
        send_command(MODE_PUT_CELL, CH_NEWLINE, 7'd3, ROW_LIMIT - 5'd1, 8'h00);
        send_command(MODE_CLEAR, 8'h00, 7'd0, 5'd0, 8'h00);
        send_command(MODE_READ_CELL, 8'h00, 7'd40, 5'd12, 8'h00);
        // unused modes change nothing
        for (int m = FIRST_UNUSED_MODE; m <= LAST_MODE; m++)
            send_command(MODE_W'(m), 8'hff, COL_TOP, ROW_TOP, 8'hff);
    endtask

    task automatic send_random_word();
        logic [MODE_W-1:0]   mode;
        logic [CHAR_W-1:0]   ch;
        logic [COLUMN_W-1:0] col;
        logic [ROW_W-1:0]    row;
        logic [ATTR_W-1:0]   attr;
        int                  pick;
        // fields a mode ignores still carry random bits
        ch = CHAR_W'($urandom);
        col = COLUMN_W'($urandom);
        row = ROW_W'($urandom);
        attr = ATTR_W'($urandom);
        if ($urandom_range(99) < 20)
            attr = '0;
        pick = int'($urandom_range(99));
        if (pick < 55)
        begin
            // typed text: mostly printable, some newlines, some raw bytes
            mode = MODE_PUT_CURSOR;
            pick = int'($urandom_range(99));
            if (pick < 12)
                ch = CH_NEWLINE;
            else if (pick < 80)
                ch = CHAR_W'($urandom_range(8'h20, 8'h7e));
        end
        else if (pick < 63)
        begin
            mode = MODE_PUT_CELL;
            if ($urandom_range(99) < 15)
                ch = CH_NEWLINE;
            if ($urandom_range(99) < 85)
            begin
                col = COLUMN_W'($urandom_range(0, COLS_DEF - 1));
                row = ROW_W'($urandom_range(0, ROWS_DEF - 1));
            end
            else if ($urandom_range(1))
                col = COLUMN_W'($urandom_range(COLS_DEF, COLUMN_MAX));
            else
                row = ROW_W'($urandom_range(ROWS_DEF, ROW_MAX));
        end
        else if (pick < 73)
            mode = MODE_BACKSPACE;
        else if (pick < 94)
        begin
            mode = MODE_READ_CELL;
            pick = int'($urandom_range(99));
            if (pick < 50)
                aim_at_last_write(col, row);
            else if (pick < 85)
            begin
                col = COLUMN_W'($urandom_range(0, COLS_DEF - 1));
                row = ROW_W'($urandom_range(0, ROWS_DEF - 1));
            end
        end
        else if (pick < 96)
            mode = MODE_CLEAR;
        else
            mode = MODE_W'($urandom_range(FIRST_UNUSED_MODE, LAST_MODE));
        // full store sweeps are costly, spend them from a budget
        if (mirror.sweeps_store(mode, ch, col, row))
        begin
            if (sweeps_left == 0)
            begin
                mode = MODE_READ_CELL;
                aim_at_last_write(col, row);
            end
            else
                sweeps_left--;
        end
        send_command(mode, ch, col, row, attr);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sweeps_left = SWEEPS_PER_PHASE;
        repeat (PHASE_WORDS)
            send_random_word();
        drain();
    endtask

    initial
    begin
        mirror = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words under the reset register values; the block's own
        // clearing pass after reset just holds off the first handshake
        run_directed();
        drain();

        // extremes: all-ones default, zero error attr, no prompt
        set_console(8'hff, 8'h00, 7'd0);
        run_phase(19, 64);

        // opposite extremes: every backspace is refused
        set_console(8'h00, 8'hff, PW_W'(COLS_DEF - 1));
        run_phase(64, 19);

        set_console(ATTR_W'($urandom_range(1, 254)), ATTR_W'($urandom_range(1, 254)),
                    PW_W'($urandom_range(1, COLS_DEF - 2)));
        run_phase(0, 0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        mirror.check_drained();
        if (mirror.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
